>>> hdl/hid_usage_ownership_counter_top_assert.svh
// Assertion macros shared by the ownership counter modules.
// Each expects clk and arst_n in the scope where it is used.
`ifndef HID_USAGE_OWNERSHIP_COUNTER_TOP_ASSERT_SVH
`define HID_USAGE_OWNERSHIP_COUNTER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HUOC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HUOC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/huoc_pkg.sv
package huoc_pkg;

	// Sizing
	localparam int NUM_SLOTS_DEF = 3;
	localparam int KEY_USAGE_MAX = 255;
	// Queue depth between front and back; must be a power of two
	localparam int QDEPTH        = 2;
	localparam logic [1:0] CNT_MAX = 2'd3;

	// Input op codes
	localparam logic OP_PRESS   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// Action types; ACT_OFF on a job means nothing to do
	localparam logic [1:0] ACT_OFF   = 2'd0;
	localparam logic [1:0] ACT_MOUSE = 2'd1;
	localparam logic [1:0] ACT_KEY   = 2'd2;

	// Result kinds
	localparam logic [1:0] EV_MOUSE = 2'd0;
	localparam logic [1:0] EV_MOD   = 2'd1;
	localparam logic [1:0] EV_KEY   = 2'd2;
	localparam logic [1:0] EV_NONE  = 2'd3;

	// Classified work item handed from front to back
	typedef struct packed {
		logic [1:0] kind;
		logic       rel;
		logic [7:0] code;
		logic [3:0] mods;
	} job_t;

	// Queue occupancy flags
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

>>> hdl/huoc_queue.sv
module huoc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  huoc_pkg::job_t    push_job,
	input  logic              pop,
	output huoc_pkg::job_t    head,
	output huoc_pkg::qstat_t  qstat
);

	localparam int AW = (huoc_pkg::QDEPTH > 1) ? $clog2(huoc_pkg::QDEPTH) : 1;

	huoc_pkg::job_t mem_q [huoc_pkg::QDEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [AW:0]    cnt_q;

	assign head        = mem_q[rd_q];
	assign qstat.full  = (cnt_q == (AW+1)'(huoc_pkg::QDEPTH));
	assign qstat.empty = (cnt_q == '0);

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	`include "hid_usage_ownership_counter_top_assert.svh"

	`HUOC_ASSERT_NOW(a_no_push_full, push, !qstat.full, "job pushed into full queue")
	`HUOC_ASSERT_NOW(a_no_pop_empty, pop, !qstat.empty, "job popped from empty queue")

endmodule

>>> hdl/huoc_front.sv
module huoc_front #(
	parameter int NUM_SLOTS = huoc_pkg::NUM_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             op,
	input  logic [1:0]       button_slot,
	input  logic [1:0]       action_type,
	input  logic [7:0]       action_code,
	input  logic [3:0]       action_modifiers,
	input  huoc_pkg::qstat_t qstat,
	output logic             push,
	output huoc_pkg::job_t   job
);

	localparam int SIW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	typedef struct packed {
		logic [1:0] atype;
		logic [7:0] code;
		logic [3:0] mods;
	} slot_t;

	slot_t          slot_q [NUM_SLOTS];
	slot_t          cur;
	logic [SIW-1:0] idx;
	logic           slot_ok;
	logic           accept;
	logic           press_ok;
	logic           rel_ok;

	function automatic logic act_valid(input logic [1:0] t, input logic [7:0] c);
		logic ok;
		ok = 1'b0;
		if (t == huoc_pkg::ACT_MOUSE) ok = (c >= 8'd1) && (c <= 8'd3);
		else if (t == huoc_pkg::ACT_KEY) ok = (c >= 8'd1) && (int'(c) <= huoc_pkg::KEY_USAGE_MAX);
		return ok;
	endfunction

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept;

	assign slot_ok = (int'(button_slot) < NUM_SLOTS);
	assign idx     = button_slot[SIW-1:0];
	assign cur     = slot_q[idx];

	// Classify: a press claims an idle slot, a release frees what the slot holds
	assign press_ok = slot_ok && (op == huoc_pkg::OP_PRESS) &&
		(cur.atype == huoc_pkg::ACT_OFF) && act_valid(action_type, action_code);
	assign rel_ok   = slot_ok && (op == huoc_pkg::OP_RELEASE) && act_valid(cur.atype, cur.code);

	always_comb begin
		job.rel  = op;
		job.kind = huoc_pkg::ACT_OFF;
		job.code = action_code;
		job.mods = action_modifiers;
		if (press_ok) begin
			job.kind = action_type;
		end else if (rel_ok) begin
			job.kind = cur.atype;
			job.code = cur.code;
			job.mods = cur.mods;
		end
	end

	// Update slot table on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) slot_q[i] <= '0;
		end else if (accept && slot_ok) begin
			if (press_ok) begin
				slot_q[idx] <= '{atype: action_type, code: action_code, mods: action_modifiers};
			end else if (op == huoc_pkg::OP_RELEASE) begin
				slot_q[idx] <= '0;
			end
		end
	end

	`include "hid_usage_ownership_counter_top_assert.svh"

	`HUOC_ASSERT_NEXT(a_rel_clears, accept && slot_ok && (op == huoc_pkg::OP_RELEASE), slot_q[$past(idx)].atype == huoc_pkg::ACT_OFF, "slot still active after release")

endmodule

>>> hdl/huoc_back.sv
module huoc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  huoc_pkg::qstat_t qstat,
	input  huoc_pkg::job_t   head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       event_kind,
	output logic [7:0]       event_code,
	output logic             event_pressed,
	output logic             last,
	output logic [2:0]       mouse_held
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PLAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]     st_q;
	huoc_pkg::job_t job_q;
	logic [4:0]     em_q;

	// Key owner counts: memory plus a valid bit per entry
	logic [1:0]     kmem [256];
	logic [255:0]   kval_q;
	logic [1:0]     kmem_rd_q;
	logic           kval_rd_q;

	logic [1:0]     mcnt_q [4];
	logic [1:0]     modc_q [4];

	logic           out_valid_q;
	logic [1:0]     kind_q;
	logic [7:0]     code_q;
	logic           pressed_q;
	logic           last_q;
	logic [2:0]     held_q;

	logic [1:0]     key_old;
	logic [1:0]     key_new;
	logic [1:0]     mouse_old;
	logic [1:0]     mouse_new;
	logic [1:0]     mod_new [4];
	logic [3:0]     mod_hit;
	logic           key_hit;
	logic [4:0]     em_plan;

	logic [2:0]     pos;
	logic [4:0]     em_rest;
	logic [1:0]     kind_d;
	logic [7:0]     code_d;
	logic           last_d;
	logic           out_free;
	logic           load;

	function automatic logic [1:0] take_cnt(input logic [1:0] c);
		return (c == huoc_pkg::CNT_MAX) ? c : c + 2'd1;
	endfunction

	function automatic logic [1:0] drop_cnt(input logic [1:0] c);
		return (c == 2'd0) ? c : c - 2'd1;
	endfunction

	assign pop      = (st_q == ST_IDLE) && !qstat.empty;
	assign out_free = !out_valid_q || out_ready;
	assign load     = (st_q == ST_EMIT) && out_free;

	// Plan: update all counts of the job and mark which steps emit
	assign key_old   = kval_rd_q ? kmem_rd_q : 2'd0;
	assign mouse_old = mcnt_q[job_q.code[1:0]];

	always_comb begin
		key_new   = key_old;
		mouse_new = mouse_old;
		mod_hit   = '0;
		key_hit   = 1'b0;
		em_plan   = '0;
		for (int b = 0; b < 4; b++) mod_new[b] = modc_q[b];
		if (job_q.kind == huoc_pkg::ACT_MOUSE) begin
			mouse_new  = job_q.rel ? drop_cnt(mouse_old) : take_cnt(mouse_old);
			em_plan[0] = job_q.rel ? (mouse_old == 2'd1) : (mouse_old == 2'd0);
		end else if (job_q.kind == huoc_pkg::ACT_KEY) begin
			for (int b = 0; b < 4; b++) begin
				if (job_q.mods[b]) begin
					mod_new[b] = job_q.rel ? drop_cnt(modc_q[b]) : take_cnt(modc_q[b]);
					mod_hit[b] = job_q.rel ? (modc_q[b] == 2'd1) : (modc_q[b] == 2'd0);
				end
			end
			key_new = job_q.rel ? drop_cnt(key_old) : take_cnt(key_old);
			key_hit = job_q.rel ? (key_old == 2'd1) : (key_old == 2'd0);
			// Press: modifiers then key; release: key then modifiers
			em_plan = job_q.rel ? {mod_hit, key_hit} : {key_hit, mod_hit};
		end
	end

	// Emit: pick the next marked step
	always_comb begin
		if (em_q[0]) pos = 3'd0;
		else if (em_q[1]) pos = 3'd1;
		else if (em_q[2]) pos = 3'd2;
		else if (em_q[3]) pos = 3'd3;
		else pos = 3'd4;
	end

	assign em_rest = em_q & (em_q - 5'd1);
	assign last_d  = (em_rest == '0);

	always_comb begin
		kind_d = huoc_pkg::EV_NONE;
		code_d = 8'd0;
		if (em_q != '0) begin
			if (job_q.kind == huoc_pkg::ACT_MOUSE) begin
				kind_d = huoc_pkg::EV_MOUSE;
				code_d = job_q.code;
			end else if (job_q.rel ? (pos == 3'd0) : (pos == 3'd4)) begin
				kind_d = huoc_pkg::EV_KEY;
				code_d = job_q.code;
			end else begin
				kind_d = huoc_pkg::EV_MOD;
				code_d = job_q.rel ? {5'd0, pos - 3'd1} : {5'd0, pos};
			end
		end
	end

	// Sequencer and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
			kval_q      <= '0;
			for (int i = 0; i < 4; i++) begin
				mcnt_q[i] <= 2'd0;
				modc_q[i] <= 2'd0;
			end
		end else begin
			// Raise valid on each load, drop it once the result transfers
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (pop) st_q <= ST_PLAN;
				end
				ST_PLAN: begin
					if (job_q.kind == huoc_pkg::ACT_MOUSE) mcnt_q[job_q.code[1:0]] <= mouse_new;
					if (job_q.kind == huoc_pkg::ACT_KEY) begin
						kval_q[job_q.code] <= 1'b1;
						for (int b = 0; b < 4; b++) modc_q[b] <= mod_new[b];
					end
					st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load && last_d) st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Job, plan mask, key memory port and result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q     <= head;
			kmem_rd_q <= kmem[head.code];
			kval_rd_q <= kval_q[head.code];
		end
		if (st_q == ST_PLAN) begin
			em_q <= em_plan;
			if (job_q.kind == huoc_pkg::ACT_KEY) kmem[job_q.code] <= key_new;
		end
		if (load) begin
			em_q      <= em_rest;
			kind_q    <= kind_d;
			code_q    <= code_d;
			pressed_q <= (kind_d != huoc_pkg::EV_NONE) && !job_q.rel;
			last_q    <= last_d;
			held_q    <= {mcnt_q[3] != 2'd0, mcnt_q[2] != 2'd0, mcnt_q[1] != 2'd0};
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = kind_q;
	assign event_code    = code_q;
	assign event_pressed = pressed_q;
	assign last          = last_q;
	assign mouse_held    = held_q;

	`include "hid_usage_ownership_counter_top_assert.svh"

	`HUOC_ASSERT_NOW(a_mouse0_idle, 1'b1, mcnt_q[0] == 2'd0, "unused mouse count changed")
	`HUOC_ASSERT_NEXT(a_plan_to_emit, st_q == ST_PLAN, st_q == ST_EMIT, "plan step not followed by emit")

endmodule

>>> hdl/hid_usage_ownership_counter_top.sv
// HID usage ownership counter.
// Input channel (in_valid/in_ready) takes one button press or release per
// transfer. The front classifies it against the slot table at once and posts
// a job into a two-entry queue; in_ready drops only while that queue is full.
// The back pops a job, reads the key owner count, then updates all owner
// counts, then drives one result per cycle while the receiver is ready on
// the output channel (out_valid/out_ready), 1 to 5 results, the final one
// with last set. The back takes a new job only once the last result of the
// current one is loaded; an item with no usage change gives a single
// no-event result.
// When the receiver stalls, the output register holds its result, the back
// waits, and the queue absorbs up to two more items before in_ready drops.
// Reset clears the slot table, every owner count (key counts through a
// valid bit per entry, so no clearing pass), the queue and the output.
module hid_usage_ownership_counter_top #(
	parameter int NUM_SLOTS = huoc_pkg::NUM_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       op,
	input  logic [1:0] button_slot,
	input  logic [1:0] action_type,
	input  logic [7:0] action_code,
	input  logic [3:0] action_modifiers,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] event_kind,
	output logic [7:0] event_code,
	output logic       event_pressed,
	output logic       last,
	output logic [2:0] mouse_held
);

	huoc_pkg::qstat_t qstat;
	huoc_pkg::job_t   push_job;
	huoc_pkg::job_t   head;
	logic             push;
	logic             pop;

	huoc_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.op               (op),
		.button_slot      (button_slot),
		.action_type      (action_type),
		.action_code      (action_code),
		.action_modifiers (action_modifiers),
		.qstat            (qstat),
		.push             (push),
		.job              (push_job)
	);

	huoc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	huoc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.qstat         (qstat),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_kind    (event_kind),
		.event_code    (event_code),
		.event_pressed (event_pressed),
		.last          (last),
		.mouse_held    (mouse_held)
	);

endmodule

>>> sim/hid_usage_ownership_counter_checker.sv
module hid_usage_ownership_counter_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic       op,
	input  logic [1:0] button_slot,
	input  logic [1:0] action_type,
	input  logic [7:0] action_code,
	input  logic [3:0] action_modifiers,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [1:0] event_kind,
	input  logic [7:0] event_code,
	input  logic       event_pressed,
	input  logic       last,
	input  logic [2:0] mouse_held,
	output int         mismatches,
	output int         outstanding
);
	import huoc_pkg::*;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] code;
		logic       pressed;
		logic       final_flag;
		logic [2:0] held;
	} usage_event_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] code;
		logic [3:0] mods;
	} slot_binding_t;

	slot_binding_t slot_tab [NUM_SLOTS_DEF];
	logic [1:0]    key_cnt [256];
	logic [1:0]    mouse_cnt [4];
	logic [1:0]    mod_cnt [4];

	usage_event_t  event_q [$];
	usage_event_t  item_events [$];

	task automatic report(input string msg);
		$display("%0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic logic action_ok(input logic [1:0] kind, input logic [7:0] code);
		case (kind)
		ACT_MOUSE: action_ok = (code >= 8'd1) && (code <= 8'd3);
		ACT_KEY:   action_ok = (code >= 8'd1) && (code <= 8'(KEY_USAGE_MAX));
		default:   action_ok = 1'b0;
		endcase
	endfunction

	// Saturating owner count steps
	function automatic logic [1:0] count_up(input logic [1:0] c);
		count_up = (c < CNT_MAX) ? c + 2'd1 : c;
	endfunction

	function automatic logic [1:0] count_down(input logic [1:0] c);
		count_down = (c == 2'd0) ? c : c - 2'd1;
	endfunction

	// Queue one usage change; held mask is taken after the count update
	task automatic post_event(input logic [1:0] kind, input logic [7:0] code,
		input logic pressed);
		usage_event_t ev;
		ev.kind       = kind;
		ev.code       = code;
		ev.pressed    = pressed;
		ev.final_flag = 1'b0;
		ev.held       = {mouse_cnt[3] != 2'd0, mouse_cnt[2] != 2'd0, mouse_cnt[1] != 2'd0};
		item_events.push_back(ev);
	endtask

	// Work out every result that one input transfer causes
	task automatic predict_item(input logic o, input logic [1:0] s, input logic [1:0] t,
		input logic [7:0] c, input logic [3:0] m);
		slot_binding_t cur;
		logic [1:0]    old;
		usage_event_t  ev;
		int            b;
		item_events.delete();
		if (s < NUM_SLOTS_DEF) begin
			cur = slot_tab[s];
			if (o == OP_PRESS) begin
				if (cur.kind == ACT_OFF && action_ok(t, c)) begin
					slot_tab[s] = '{kind: t, code: c, mods: m};
					if (t == ACT_MOUSE) begin
						old = mouse_cnt[c[1:0]];
						mouse_cnt[c[1:0]] = count_up(old);
						if (old == 2'd0) post_event(EV_MOUSE, c, 1'b1);
					end else begin
						// modifiers go down before the key
						for (b = 0; b < 4; b++) begin
							if (m[b]) begin
								old = mod_cnt[b];
								mod_cnt[b] = count_up(old);
								if (old == 2'd0) post_event(EV_MOD, 8'(b), 1'b1);
							end
						end
						old = key_cnt[c];
						key_cnt[c] = count_up(old);
						if (old == 2'd0) post_event(EV_KEY, c, 1'b1);
					end
				end
			end else begin
				if (action_ok(cur.kind, cur.code)) begin
					if (cur.kind == ACT_MOUSE) begin
						old = mouse_cnt[cur.code[1:0]];
						mouse_cnt[cur.code[1:0]] = count_down(old);
						if (old == 2'd1) post_event(EV_MOUSE, cur.code, 1'b0);
					end else begin
						// key goes up before the modifiers
						old = key_cnt[cur.code];
						key_cnt[cur.code] = count_down(old);
						if (old == 2'd1) post_event(EV_KEY, cur.code, 1'b0);
						for (b = 0; b < 4; b++) begin
							if (cur.mods[b]) begin
								old = mod_cnt[b];
								mod_cnt[b] = count_down(old);
								if (old == 2'd1) post_event(EV_MOD, 8'(b), 1'b0);
							end
						end
					end
				end
				slot_tab[s] = '0;
			end
		end
		if (item_events.size() == 0) post_event(EV_NONE, 8'd0, 1'b0);
		ev = item_events.pop_back();
		ev.final_flag = 1'b1;
		item_events.push_back(ev);
		foreach (item_events[i]) event_q.push_back(item_events[i]);
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
		input logic [7:0] want);
		if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// Compare one output transfer against the oldest expectation
	task automatic check_result();
		usage_event_t want;
		if (event_q.size() == 0) begin
			report($sformatf("result kind %0d code %0d with nothing pending",
				event_kind, event_code));
		end else begin
			want = event_q.pop_front();
			check_field("event_kind", event_kind, want.kind);
			check_field("event_code", event_code, want.code);
			check_field("event_pressed", event_pressed, want.pressed);
			check_field("last", last, want.final_flag);
			check_field("mouse_held", mouse_held, want.held);
		end
	endtask

	// Retire results before predicting, so a stray result never matches new work
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (slot_tab[i]) slot_tab[i] = '0;
			foreach (key_cnt[i]) key_cnt[i] = 2'd0;
			foreach (mouse_cnt[i]) mouse_cnt[i] = 2'd0;
			foreach (mod_cnt[i]) mod_cnt[i] = 2'd0;
			event_q.delete();
		end else begin
			if (out_valid && out_ready) check_result();
			if (in_valid && in_ready)
				predict_item(op, button_slot, action_type, action_code, action_modifiers);
		end
		outstanding = event_q.size();
	end

endmodule

>>> sim/tb_hid_usage_ownership_counter_top.sv
module tb_hid_usage_ownership_counter_top;
	import huoc_pkg::*;

	localparam int         IDLE_LIMIT   = 1000;
	localparam int         HOLD_CYCLES  = 60;
	localparam int         PHASE_ITEMS  = 112;
	localparam logic [1:0] ACT_UNDEF    = 2'd3;
	localparam logic [1:0] SLOT_NONE    = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       op;
	logic [1:0] button_slot;
	logic [1:0] action_type;
	logic [7:0] action_code;
	logic [3:0] action_modifiers;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] event_kind;
	logic [7:0] event_code;
	logic       event_pressed;
	logic       last;
	logic [2:0] mouse_held;

	int         mismatches;
	int         outstanding;
	int         gap_pct   = 0;
	int         stall_pct = 0;
	int         hold_req  = 0;
	logic [2:0] slot_busy = '0;

	always #2 clk = ~clk;

	hid_usage_ownership_counter_top u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.op               (op),
		.button_slot      (button_slot),
		.action_type      (action_type),
		.action_code      (action_code),
		.action_modifiers (action_modifiers),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.event_kind       (event_kind),
		.event_code       (event_code),
		.event_pressed    (event_pressed),
		.last             (last),
		.mouse_held       (mouse_held)
	);

	hid_usage_ownership_counter_checker u_usage_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.op               (op),
		.button_slot      (button_slot),
		.action_type      (action_type),
		.action_code      (action_code),
		.action_modifiers (action_modifiers),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.event_kind       (event_kind),
		.event_code       (event_code),
		.event_pressed    (event_pressed),
		.last             (last),
		.mouse_held       (mouse_held),
		.mismatches       (mismatches),
		.outstanding      (outstanding)
	);

	// Drive out_ready; a new hold request blocks the output for a long stretch
	initial begin
		int seen;
		int left;
		seen = 0;
		left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != seen) begin
				seen = hold_req;
				left = HOLD_CYCLES;
			end
			if (left > 0) begin
				out_ready = 1'b0;
				left--;
			end else begin
				out_ready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// End the run when no transfer happens for too long
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Offer one button event and hold it until the transfer; returns at a falling edge
	task automatic send_item(input logic o, input logic [1:0] s, input logic [1:0] t,
		input logic [7:0] c, input logic [3:0] m);
		int gap;
		gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		op               = o;
		button_slot      = s;
		action_type      = t;
		action_code      = c;
		action_modifiers = m;
		in_valid         = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Mostly press/release pairs on real slots sharing a few usages; some junk
	task automatic send_random();
		logic       o;
		logic [1:0] s;
		logic [1:0] t;
		logic [7:0] c;
		logic [3:0] m;
		logic       good;
		s = ($urandom_range(19) == 0) ? SLOT_NONE : 2'($urandom_range(2));
		if (s != SLOT_NONE && slot_busy[s])
			o = ($urandom_range(9) < 8) ? OP_RELEASE : OP_PRESS;
		else
			o = ($urandom_range(9) < 2) ? OP_RELEASE : OP_PRESS;
		m = 4'($urandom_range(15));
		good = ($urandom_range(99) < 85);
		if (good) begin
			if ($urandom_range(2) == 0) begin
				t = ACT_MOUSE;
				c = 8'($urandom_range(1, 3));
			end else begin
				t = ACT_KEY;
				case ($urandom_range(3))
				0:       c = 8'($urandom_range(1, 255));
				1:       c = 8'd255;
				default: c = 8'($urandom_range(1, 3));
				endcase
			end
		end else begin
			case ($urandom_range(3))
			0: begin
				t = ACT_OFF;
				c = 8'($urandom_range(255));
			end
			1: begin
				t = ACT_UNDEF;
				c = 8'($urandom_range(255));
			end
			2: begin
				t = ACT_MOUSE;
				c = $urandom_range(1) ? 8'd0 : 8'($urandom_range(4, 255));
			end
			default: begin
				t = ACT_KEY;
				c = 8'd0;
			end
			endcase
		end
		send_item(o, s, t, c, m);
		// track occupancy only to steer the op choice
		if (s != SLOT_NONE) begin
			if (o == OP_RELEASE) slot_busy[s] = 1'b0;
			else if (good) slot_busy[s] = 1'b1;
		end
	endtask

	task automatic drain();
		in_valid = 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	initial begin
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		op               = OP_PRESS;
		button_slot      = 2'd0;
		action_type      = ACT_OFF;
		action_code      = 8'd0;
		action_modifiers = 4'd0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: sharing, saturation, invalid actions, idle and absent slots
		send_item(OP_RELEASE, 2'd0, ACT_KEY, 8'hA5, 4'hF);
		send_item(OP_PRESS, 2'd0, ACT_MOUSE, 8'd1, 4'h0);
		send_item(OP_PRESS, 2'd1, ACT_MOUSE, 8'd1, 4'h0);
		send_item(OP_PRESS, 2'd0, ACT_KEY, 8'h04, 4'h1);
		send_item(OP_RELEASE, 2'd0, ACT_OFF, 8'd0, 4'h0);
		send_item(OP_RELEASE, 2'd1, ACT_OFF, 8'd0, 4'h0);
		send_item(OP_PRESS, 2'd2, ACT_KEY, 8'd255, 4'hF);
		send_item(OP_PRESS, 2'd0, ACT_KEY, 8'd255, 4'h5);
		send_item(OP_PRESS, 2'd1, ACT_MOUSE, 8'd3, 4'h0);
		send_item(OP_PRESS, SLOT_NONE, ACT_MOUSE, 8'd2, 4'h0);
		send_item(OP_RELEASE, SLOT_NONE, ACT_MOUSE, 8'd2, 4'h0);
		send_item(OP_RELEASE, 2'd1, ACT_UNDEF, 8'hFF, 4'hF);
		send_item(OP_PRESS, 2'd1, ACT_OFF, 8'd1, 4'h0);
		send_item(OP_PRESS, 2'd1, ACT_MOUSE, 8'd0, 4'h0);
		send_item(OP_PRESS, 2'd1, ACT_UNDEF, 8'd1, 4'h0);
		send_item(OP_PRESS, 2'd1, ACT_KEY, 8'd0, 4'hF);
		send_item(OP_PRESS, 2'd1, ACT_MOUSE, 8'd2, 4'h0);
		send_item(OP_RELEASE, 2'd2, ACT_OFF, 8'd0, 4'h0);
		send_item(OP_RELEASE, 2'd0, ACT_OFF, 8'd0, 4'h0);
		send_item(OP_RELEASE, 2'd1, ACT_OFF, 8'd0, 4'h0);
		for (int i = 0; i < 3; i++)
			send_item(OP_PRESS, 2'(i), ACT_KEY, 8'h80, 4'h8);
		for (int i = 0; i < 3; i++)
			send_item(OP_RELEASE, 2'(i), ACT_OFF, 8'd0, 4'h0);
		drain();

		// Random phases: free flow with a long output hold, then sender gaps,
		// receiver stalls, and both
		for (int p = 0; p < 4; p++) begin
			case (p)
			0: begin
				gap_pct = 0;
				stall_pct = 0;
				hold_req++;
			end
			1: begin
				gap_pct = 60;
				stall_pct = 0;
			end
			2: begin
				gap_pct = 0;
				stall_pct = 60;
			end
			default: begin
				gap_pct = 20;
				stall_pct = 20;
			end
			endcase
			repeat (PHASE_ITEMS) send_random();
			drain();
		end

		// Let any stray result show up before the verdict
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
